// ----- rtl/hle_pkg.sv -----
package hle_pkg;

    // Field and arithmetic widths
    localparam int MAX_EXTENT = 256;
    localparam int DIM_W      = 9;
    localparam int COORD_W    = 8;
    localparam int IDX_W      = 24;
    localparam int RC_W       = 16;
    localparam int CA_W       = 17;
    localparam int NUM_DIR    = 6;
    localparam int NUM_NBR    = 8;
    localparam int SLOT_W     = 3;
    localparam int CFG_IDX_W  = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ALTS = 2'd2;

    // Neighbor slots in the candidate mask: hex directions first, then vertical
    localparam logic [SLOT_W-1:0] SLOT_BELOW = 3'd6;
    localparam logic [SLOT_W-1:0] SLOT_ABOVE = 3'd7;

    // Odd-r offsets, [parity][direction]; parity 0 is an even row
    localparam logic signed [1:0] HEX_DCOL [0:1][0:NUM_DIR-1] = '{
        '{ 2'sd1,  2'sd0, -2'sd1, -2'sd1, -2'sd1,  2'sd0},
        '{ 2'sd1,  2'sd1,  2'sd0, -2'sd1,  2'sd0,  2'sd1}
    };
    localparam logic signed [1:0] HEX_DROW [0:1][0:NUM_DIR-1] = '{
        '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0,  2'sd1,  2'sd1},
        '{ 2'sd0, -2'sd1, -2'sd1,  2'sd0,  2'sd1,  2'sd1}
    };

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic [COORD_W-1:0] cell_alt;
    } t_cell_in;

    typedef struct packed {
        logic [COORD_W-1:0] nbr_row;
        logic [COORD_W-1:0] nbr_col;
        logic [COORD_W-1:0] nbr_alt;
        logic [IDX_W-1:0]   nbr_index;
        logic               last;
    } t_nbr_out;

    // Grid dimensions after clamping
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] alts;
    } t_dims;

    // Classified query waiting for the back end
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] alt;
        logic [NUM_NBR-1:0] mask;
        logic [IDX_W-1:0]   base;
        logic [CA_W-1:0]    ca;
    } t_hle_entry;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_EXTENT)) ? DIM_W'(MAX_EXTENT) : v;
    endfunction

endpackage

// ----- rtl/hex_layered_neighbor_enumerator.sv -----
// Layered odd-r hex grid neighbor enumerator. Each query cell word yields,
// in order, its in-bounds same-layer hex neighbors (east, upper pair, west,
// lower pair), then the cell below and the cell above where they exist, each
// with its linear index row*cols*alts + col*alts + alt (mod 2^24) and last
// set on the final word. Results leave at one word per cycle while the
// output register is free, and the next query's first word follows its
// predecessor's last with no gap when the queue holds it. A query with no
// neighbor yields nothing and is dropped at the front, never queued. The
// first result passes stage A, the queue, the work and output registers.
// A two-word queue lets the front classify further queries while the back
// end walks the current one. Configuration writes are always ready and
// registered; dimensions above 256 are used as 256.
module hex_layered_neighbor_enumerator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  hle_pkg::t_cell_in              i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output hle_pkg::t_nbr_out              o_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hle_pkg::DIM_W-1:0]      i_cfg_data
);
    import hle_pkg::*;

    logic [DIM_W-1:0] r_num_rows, r_num_cols, r_num_alts;
    t_dims            dims;
    logic             q_full, q_push, q_pop, q_valid;
    t_hle_entry       push_entry, head_entry;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= DIM_W'(16);
            r_num_cols <= DIM_W'(16);
            r_num_alts <= DIM_W'(16);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                CFG_NUM_ALTS: r_num_alts <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign dims.rows = clamp_dim(r_num_rows);
    assign dims.cols = clamp_dim(r_num_cols);
    assign dims.alts = clamp_dim(r_num_alts);

    hle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dims   (dims),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (push_entry)
    );

    hle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    hle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_alts    (dims.alts),
        .i_q_valid (q_valid),
        .i_entry   (head_entry),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

// ----- rtl/hle_front.sv -----
module hle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hle_pkg::t_dims    i_dims,
    input  logic              i_valid,
    output logic              o_ready,
    input  hle_pkg::t_cell_in i_data,
    input  logic              i_q_full,
    output logic              o_push,
    output hle_pkg::t_hle_entry o_entry
);
    import hle_pkg::*;

    // Bound test of one coordinate moved by -1, 0 or +1
    function automatic logic in_range(input logic [COORD_W-1:0] v,
                                      input logic signed [1:0] s,
                                      input logic [DIM_W-1:0] n);
        logic signed [DIM_W:0] nv;
        nv = $signed({2'b00, v}) + $signed({{(DIM_W-1){s[1]}}, s});
        return !nv[DIM_W] && (nv[DIM_W-1:0] < n);
    endfunction

    logic                r_a_valid;
    logic [COORD_W-1:0]  r_row, r_col, r_alt;
    logic [NUM_NBR-1:0]  r_mask;
    logic [RC_W-1:0]     r_rc;
    logic [CA_W-1:0]     r_ca;

    logic [NUM_NBR-1:0]  n_mask;
    logic                par;
    logic                adv;

    // Candidate mask of the incoming query
    always_comb begin
        par = i_data.cell_row[0];
        for (int d = 0; d < NUM_DIR; d++) begin
            n_mask[d] = in_range(i_data.cell_row, HEX_DROW[par][d], i_dims.rows) &&
                        in_range(i_data.cell_col, HEX_DCOL[par][d], i_dims.cols);
        end
        n_mask[SLOT_BELOW] = (i_data.cell_alt != '0);
        n_mask[SLOT_ABOVE] = ({1'b0, i_data.cell_alt} + DIM_W'(1)) < i_dims.alts;
    end

    // Stage A advances when empty, when it holds a query with no result,
    // or when the queue takes its word
    assign adv     = !r_a_valid || (r_mask == '0) || !i_q_full;
    assign o_ready = adv;
    assign o_push  = r_a_valid && (r_mask != '0) && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid;
        end
    end

    // Stage A payload: first products of the linear index
    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_row  <= i_data.cell_row;
            r_col  <= i_data.cell_col;
            r_alt  <= i_data.cell_alt;
            r_mask <= n_mask;
            r_rc   <= ({8'b0, i_data.cell_row} * {7'b0, i_dims.cols})
                      + {8'b0, i_data.cell_col};
            r_ca   <= {8'b0, i_dims.cols} * {8'b0, i_dims.alts};
        end
    end

    // Base index (row*cols + col)*alts + alt, registered in the queue
    always_comb begin
        o_entry.row  = r_row;
        o_entry.col  = r_col;
        o_entry.alt  = r_alt;
        o_entry.mask = r_mask;
        o_entry.ca   = r_ca;
        o_entry.base = ({8'b0, r_rc} * {15'b0, i_dims.alts}) + {16'b0, r_alt};
    end

endmodule

// ----- rtl/hle_queue.sv -----
module hle_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hle_pkg::t_hle_entry i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output hle_pkg::t_hle_entry o_entry
);
    import hle_pkg::*;

    // Two-word queue between front and back
    t_hle_entry r_mem [0:1];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= !r_wr_ptr;
            if (do_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- rtl/hle_back.sv -----
module hle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [hle_pkg::DIM_W-1:0] i_alts,
    input  logic                i_q_valid,
    input  hle_pkg::t_hle_entry i_entry,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output hle_pkg::t_nbr_out   o_data
);
    import hle_pkg::*;

    t_hle_entry r_work;
    logic       r_work_valid;
    t_nbr_out   r_out;
    logic       r_out_valid;

    logic [NUM_NBR-1:0] rem;
    logic [SLOT_W-1:0]  sel;
    logic               out_free, emit, done;
    logic signed [1:0]  dr, dc;
    logic [IDX_W-1:0]   row_term, col_term, alt_term;
    t_nbr_out           n_out;

    // Lowest pending slot and what stays after it
    always_comb begin
        sel = '0;
        for (int i = NUM_NBR - 1; i >= 0; i--) begin
            if (r_work.mask[i]) sel = SLOT_W'(i);
        end
        rem = r_work.mask & (r_work.mask - NUM_NBR'(1));
    end

    // Neighbor coordinates and index offset from the base
    always_comb begin
        dr       = 2'sd0;
        dc       = 2'sd0;
        alt_term = '0;
        n_out.nbr_alt = r_work.alt;
        case (sel)
            SLOT_BELOW: begin
                n_out.nbr_alt = r_work.alt - COORD_W'(1);
                alt_term      = '1;
            end
            SLOT_ABOVE: begin
                n_out.nbr_alt = r_work.alt + COORD_W'(1);
                alt_term      = IDX_W'(1);
            end
            default: begin
                dr = HEX_DROW[r_work.row[0]][sel];
                dc = HEX_DCOL[r_work.row[0]][sel];
            end
        endcase
        n_out.nbr_row = r_work.row + {{(COORD_W-2){dr[1]}}, dr};
        n_out.nbr_col = r_work.col + {{(COORD_W-2){dc[1]}}, dc};
        case (dr)
            2'sd1:   row_term = {7'b0, r_work.ca};
            -2'sd1:  row_term = -{7'b0, r_work.ca};
            default: row_term = '0;
        endcase
        case (dc)
            2'sd1:   col_term = {15'b0, i_alts};
            -2'sd1:  col_term = -{15'b0, i_alts};
            default: col_term = '0;
        endcase
        n_out.nbr_index = r_work.base + row_term + col_term + alt_term;
        n_out.last      = (rem == '0);
    end

    // One result word per cycle into the output register while it is free
    assign out_free = !r_out_valid || i_ready;
    assign emit     = r_work_valid && out_free;
    assign done     = emit && (rem == '0);
    assign o_pop    = i_q_valid && (!r_work_valid || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop)      r_work_valid <= 1'b1;
            else if (done)  r_work_valid <= 1'b0;
            if (emit)         r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_entry;
        end else if (emit) begin
            r_work.mask <= rem;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- rtl/hle_checker.sv -----
module hle_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  hle_pkg::t_nbr_out              o_data
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // Words of one query leave back to back
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_data.last |=> o_valid)
        else $error("gap inside a query's result burst");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind hex_layered_neighbor_enumerator hle_checker u_hle_checker (.*);

// ----- bench/hex_layered_neighbor_enumerator_tb.sv -----
module hex_layered_neighbor_enumerator_tb;
    import hle_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT     = 28;

    // Odd-r direction offsets: east, upper pair, west, lower pair
    localparam int DCOL_EVEN [6] = '{1, 0, -1, -1, -1, 0};
    localparam int DCOL_ODD  [6] = '{1, 1, 0, -1, 0, 1};
    localparam int DROW      [6] = '{0, -1, -1, 0, 1, 1};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_cell_in             i_data;
    logic                 o_valid;
    logic                 i_ready;
    t_nbr_out             o_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    // Grid dimensions as last written to the block
    logic [DIM_W-1:0] grid_rows;
    logic [DIM_W-1:0] grid_cols;
    logic [DIM_W-1:0] grid_alts;

    t_nbr_out nbr_expected [$];
    t_nbr_out nbr_want;
    int       errors;
    int       cycles;
    int       stall_left;
    bit       steady;

    hex_layered_neighbor_enumerator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        return (v > 9'd256) ? 256 : int'(v);
    endfunction

    function automatic t_nbr_out make_nbr(input int r, input int c, input int a,
                                          input int cols, input int alts);
        t_nbr_out   w;
        logic [31:0] lin;
        lin         = r * cols * alts + c * alts + a;
        w.nbr_row   = r[7:0];
        w.nbr_col   = c[7:0];
        w.nbr_alt   = a[7:0];
        w.nbr_index = lin[IDX_W-1:0];
        w.last      = 1'b0;
        return w;
    endfunction

    // Expected neighbor words of one query, queued in emission order
    function automatic void predict_neighbors(input t_cell_in q);
        t_nbr_out res [8];
        int       n;
        int       rows;
        int       cols;
        int       alts;
        int       r;
        int       c;
        int       a;
        int       nr;
        int       nc;
        rows = eff_dim(grid_rows);
        cols = eff_dim(grid_cols);
        alts = eff_dim(grid_alts);
        r    = q.cell_row;
        c    = q.cell_col;
        a    = q.cell_alt;
        n    = 0;
        for (int d = 0; d < 6; d++) begin
            nc = c + (r[0] ? DCOL_ODD[d] : DCOL_EVEN[d]);
            nr = r + DROW[d];
            if (nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
                res[n] = make_nbr(nr, nc, a, cols, alts);
                n++;
            end
        end
        if (a > 0) begin
            res[n] = make_nbr(r, c, a - 1, cols, alts);
            n++;
        end
        if (a + 1 < alts) begin
            res[n] = make_nbr(r, c, a + 1, cols, alts);
            n++;
        end
        if (n > 0)
            res[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            nbr_expected = {nbr_expected, res[k]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (nbr_expected.size() == 0) begin
                report_mismatch("unexpected word, index", o_data.nbr_index, 0);
            end else begin
                nbr_want = nbr_expected.pop_front();
                if (o_data.nbr_row !== nbr_want.nbr_row)
                    report_mismatch("nbr_row", o_data.nbr_row, nbr_want.nbr_row);
                if (o_data.nbr_col !== nbr_want.nbr_col)
                    report_mismatch("nbr_col", o_data.nbr_col, nbr_want.nbr_col);
                if (o_data.nbr_alt !== nbr_want.nbr_alt)
                    report_mismatch("nbr_alt", o_data.nbr_alt, nbr_want.nbr_alt);
                if (o_data.nbr_index !== nbr_want.nbr_index)
                    report_mismatch("nbr_index", o_data.nbr_index, nbr_want.nbr_index);
                if (o_data.last !== nbr_want.last)
                    report_mismatch("last", o_data.last, nbr_want.last);
            end
        end
    end

    // Receiver: long hold-off first, then steady or random readiness
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Offer one query word; valid stays up when the next one follows at once
    task automatic send_qry(input logic [7:0] r, input logic [7:0] c, input logic [7:0] a);
        t_cell_in q;
        q.cell_row = r;
        q.cell_col = c;
        q.cell_alt = a;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= q;
        do @(posedge i_clk); while (!o_ready);
        predict_neighbors(q);
    endtask

    // Let every queued word come out, then cover queries that yield nothing
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (nbr_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NUM_ROWS: grid_rows = v;
            CFG_NUM_COLS: grid_cols = v;
            CFG_NUM_ALTS: grid_alts = v;
            default: ;
        endcase
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                            input logic [DIM_W-1:0] a);
        write_reg(CFG_NUM_ROWS, r);
        write_reg(CFG_NUM_COLS, c);
        write_reg(CFG_NUM_ALTS, a);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly inside the grid, sometimes anywhere in the field
    function automatic logic [7:0] pick_coord(input int extent);
        if (extent == 0 || $urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(extent - 1));
    endfunction

    // Reset dimensions: corners, edges of both row parities, interior
    task automatic test_default_grid();
        send_qry(0, 0, 0);
        send_qry(15, 15, 15);
        send_qry(0, 15, 0);
        send_qry(15, 0, 15);
        send_qry(1, 0, 5);
        send_qry(1, 15, 7);
        send_qry(2, 7, 8);
        send_qry(3, 7, 8);
        wait_idle();
    endtask

    // Smallest legal grid, full grid, and dimensions clamped to 256
    task automatic test_dim_extremes();
        set_dims(2, 2, 2);
        send_qry(0, 0, 0);
        send_qry(1, 1, 1);
        send_qry(0, 1, 1);
        send_qry(1, 0, 0);
        wait_idle();
        set_dims(256, 256, 256);
        send_qry(255, 255, 255);
        send_qry(0, 0, 0);
        send_qry(255, 0, 128);
        send_qry(128, 255, 0);
        wait_idle();
        set_dims(511, 300, 257);
        send_qry(255, 255, 254);
        send_qry(200, 100, 0);
        wait_idle();
    endtask

    // Zero and one dimensions, queries with no result, queries off the grid
    task automatic test_degenerate_dims();
        set_dims(0, 0, 0);
        send_qry(0, 0, 0);
        send_qry(5, 5, 5);
        wait_idle();
        set_dims(1, 1, 1);
        send_qry(0, 0, 0);
        wait_idle();
        set_dims(4, 4, 4);
        send_qry(200, 200, 200);
        send_qry(4, 3, 2);
        wait_idle();
    endtask

    task automatic test_random_grids();
        int rows;
        int cols;
        int alts;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: set_dims(256, 256, 256);
                1: set_dims(DIM_W'($urandom_range(2, 256)), DIM_W'($urandom_range(2, 256)),
                            DIM_W'($urandom_range(2, 256)));
                2: set_dims(DIM_W'($urandom_range(511)), DIM_W'($urandom_range(511)),
                            DIM_W'($urandom_range(511)));
                default: set_dims(DIM_W'($urandom_range(2, 12)), DIM_W'($urandom_range(2, 12)),
                                  DIM_W'($urandom_range(2, 12)));
            endcase
            rows   = eff_dim(grid_rows);
            cols   = eff_dim(grid_cols);
            alts   = eff_dim(grid_alts);
            // one phase runs with no idling on either side
            steady = (p == 3);
            repeat (75) send_qry(pick_coord(rows), pick_coord(cols), pick_coord(alts));
            wait_idle();
        end
        steady = 1'b0;
    endtask

    // Receiver holds off while queries keep coming, so the input stalls
    task automatic test_output_stall();
        set_dims(8, 8, 8);
        steady     = 1'b1;
        stall_left = 150;
        repeat (40) send_qry(pick_coord(8), pick_coord(8), pick_coord(8));
        wait_idle();
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_NUM_ROWS;
        i_cfg_data  = '0;
        grid_rows   = 9'd16;
        grid_cols   = 9'd16;
        grid_alts   = 9'd16;
        errors      = 0;
        cycles      = 0;
        stall_left  = 0;
        steady      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_grid();
        test_dim_extremes();
        test_degenerate_dims();
        test_random_grids();
        test_output_stall();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
